>>> rtl/wope_pkg.sv
`timescale 1ns / 1ps
package wope_pkg;

   // default sizing
   localparam int POS_BITS_DEFAULT       = 32;
   localparam int CODEC_ID_LIMIT_DEFAULT = 32;

   // result queue sizing
   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   // summary status codes
   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_BAD_EBML   = 2'd1;
   localparam logic [1:0] STATUS_NO_SEGMENT = 2'd2;
   localparam logic [1:0] STATUS_NO_OPUS    = 2'd3;

   // result kinds
   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   // element ids and values
   localparam logic [31:0] ID_TRACKS      = 32'h1654_AE6B;
   localparam logic [31:0] ID_CLUSTER     = 32'h1F43_B675;
   localparam logic [31:0] ID_TRACKENTRY  = 32'h0000_00AE;
   localparam logic [31:0] ID_TRACKNUMBER = 32'h0000_00D7;
   localparam logic [31:0] ID_TRACKTYPE   = 32'h0000_0083;
   localparam logic [31:0] ID_CODECID     = 32'h0000_0086;
   localparam logic [31:0] ID_AUDIO       = 32'h0000_00E1;
   localparam logic [31:0] ID_CHANNELS    = 32'h0000_009F;
   localparam logic [31:0] ID_SIMPLEBLOCK = 32'h0000_00A3;
   localparam logic [7:0]  TYPE_AUDIO     = 8'h02;
   localparam logic [7:0]  TRACK_MASK     = 8'h7F;
   localparam logic [31:0] OPUS_WORD      = 32'h4F50_5553;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_file;
   } req_type;

   typedef struct packed {
      logic        out_kind;
      logic [7:0]  payload_byte;
      logic        packet_end;
      logic        packet_aborted;
      logic [1:0]  parse_status;
      logic [31:0] opus_track;
      logic [15:0] channel_count;
      logic [15:0] packets_seen;
      logic        last_of_run;
   } rsp_type;

   // up to two results produced by one request
   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } push_type;

   // total vint length from the leading byte (9 for a zero byte)
   function automatic logic [3:0] vint_len(input logic [7:0] b);
      logic [3:0] n;
      casez (b)
         8'b1???????: n = 4'd1;
         8'b01??????: n = 4'd2;
         8'b001?????: n = 4'd3;
         8'b0001????: n = 4'd4;
         8'b00001???: n = 4'd5;
         8'b000001??: n = 4'd6;
         8'b0000001?: n = 4'd7;
         8'b00000001: n = 4'd8;
         default:     n = 4'd9;
      endcase
      return n;
   endfunction

   function automatic logic [7:0] ebml_magic(input logic [1:0] idx);
      logic [7:0] v;
      case (idx)
         2'd0:    v = 8'h1A;
         2'd1:    v = 8'h45;
         2'd2:    v = 8'hDF;
         default: v = 8'hA3;
      endcase
      return v;
   endfunction

   function automatic logic [7:0] segment_magic(input logic [1:0] idx);
      logic [7:0] v;
      case (idx)
         2'd0:    v = 8'h18;
         2'd1:    v = 8'h53;
         2'd2:    v = 8'h80;
         default: v = 8'h67;
      endcase
      return v;
   endfunction

endpackage

>>> rtl/wope_queue.sv
`timescale 1ns / 1ps
module wope_queue (
   input  logic              clock,
   input  logic              reset,
   input  wope_pkg::push_type push,
   output logic              no_room,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output wope_pkg::rsp_type rsp_data
);
   import wope_pkg::*;

   rsp_type                   mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                      pop;

   // head of queue drives the result channel
   assign rsp_valid = (cnt_ff != '0);
   assign rsp_data  = mem_ff[rd_ptr_ff];
   assign pop       = rsp_valid && !rsp_stall;
   assign no_room   = cnt_ff > QUEUE_CNT_BITS'(QUEUE_DEPTH - 2);

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff + QUEUE_PTR_BITS'(push.count);
      rd_ptr_in = rd_ptr_ff + QUEUE_PTR_BITS'(pop);
      cnt_in    = cnt_ff + QUEUE_CNT_BITS'(push.count) - QUEUE_CNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // result storage
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_ptr_ff + QUEUE_PTR_BITS'(1)] <= push.second;
      end
   end

endmodule

>>> rtl/wope_parser.sv
`timescale 1ns / 1ps
module wope_parser #(
   parameter int POS_BITS       = wope_pkg::POS_BITS_DEFAULT,
   parameter int CODEC_ID_LIMIT = wope_pkg::CODEC_ID_LIMIT_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  wope_pkg::req_type  req,
   output wope_pkg::push_type push
);
   import wope_pkg::*;

   localparam int          NLEVELS = 5;
   localparam logic [64:0] POS_MAX = (65'd1 << POS_BITS) - 65'd1;

   typedef enum logic [3:0] {
      PH_MAGIC, PH_HSIZE, PH_HSIZE_MORE, PH_HSKIP, PH_SMAGIC, PH_SSIZE,
      PH_SSIZE_MORE, PH_ID, PH_ID_MORE, PH_SIZE, PH_SIZE_MORE, PH_DRAIN,
      PH_CONTENT, PH_DONE
   } phase_type;

   typedef enum logic [3:0] {
      K_SEG, K_SKIP, K_TRACKS, K_ENTRY, K_AUDIO, K_CLUSTER, K_NUM, K_TYPE,
      K_CODEC, K_CHAN, K_BLOCK
   } kind_type;

   typedef struct packed {
      phase_type                          phase;
      logic [POS_BITS-1:0]                pos;
      logic [NLEVELS-1:0][POS_BITS-1:0]   lend;
      logic [NLEVELS-1:0]                 unb;
      kind_type [NLEVELS-1:0]             kind;
      logic [2:0]                         depth;
      logic [31:0]                        id;
      logic [63:0]                        size;
      logic [3:0]                         left;
      logic                               all_ones;
      logic [31:0]                        trk;
      logic [2:0]                         flags;
      logic [31:0]                        codec;
      logic [15:0]                        chtmp;
      logic [15:0]                        chreg;
      logic [31:0]                        sel;
      logic                               found;
      logic [2:0]                         bidx;
      logic                               bmatch;
      logic [15:0]                        pkt;
      logic [1:0]                         status;
   } state_type;

   state_type state_ff, state_in;

   function automatic state_type reset_state();
      state_type r;
      r       = '0;
      r.phase = PH_MAGIC;
      r.chtmp = 16'd1;
      r.chreg = 16'd1;
      return r;
   endfunction

   // end position with saturation at the position limit
   function automatic logic [POS_BITS-1:0] sat_add(input logic [POS_BITS-1:0] a,
                                                   input logic [63:0] s);
      logic [64:0] sum;
      sum = 65'(a) + {1'b0, s};
      if (sum > POS_MAX) begin
         return POS_MAX[POS_BITS-1:0];
      end
      return sum[POS_BITS-1:0];
   endfunction

   // per-byte parse step
   always_comb begin
      state_type           s;
      logic [7:0]          b;
      logic [POS_BITS-1:0] pos_new;
      logic                do_open;
      logic [2:0]          p;
      logic [2:0]          c;
      kind_type            k;
      logic [POS_BITS-1:0] e;
      logic [31:0]         cw;
      logic [NLEVELS-1:0]  closable;
      logic                run;
      logic                drain;
      logic                last;
      logic                have_pay;
      logic [1:0]          st;
      logic [3:0]          len;
      logic [7:0]          vmask;
      rsp_type             pay;
      rsp_type             summ;

      s        = state_ff;
      b        = req.in_byte;
      do_open  = 1'b0;
      have_pay = 1'b0;
      last     = 1'b0;
      pay      = '0;
      summ     = '0;
      p        = '0;
      c        = '0;
      k        = K_SKIP;
      e        = '0;
      cw       = '0;
      drain    = 1'b0;
      st       = STATUS_OK;
      len      = vint_len(b);
      vmask    = 8'hFF >> len;
      pos_new  = (65'(s.pos) < POS_MAX) ? s.pos + POS_BITS'(1) : s.pos;
      s.pos    = pos_new;

      case (state_ff.phase)
         PH_MAGIC: begin
            if (b != ebml_magic(state_ff.pos[1:0])) begin
               s.phase  = PH_DONE;
               s.status = STATUS_BAD_EBML;
            end else if (state_ff.pos >= POS_BITS'(3)) begin
               s.phase = PH_HSIZE;
            end
         end
         PH_HSIZE: begin
            if (b == 8'd0) begin
               s.size = '0;
               s.left = '0;
            end else begin
               s.size     = 64'(b & vmask);
               s.all_ones = (b & vmask) == vmask;
               s.left     = len - 4'd1;
            end
            if (s.left != 4'd0) begin
               s.phase = PH_HSIZE_MORE;
            end else begin
               s.phase = (s.size != '0) ? PH_HSKIP : PH_SMAGIC;
            end
         end
         PH_HSIZE_MORE: begin
            s.size     = {s.size[55:0], b};
            s.all_ones = s.all_ones && (b == 8'hFF);
            s.left     = s.left - 4'd1;
            if (s.left == 4'd0) begin
               s.phase = (s.size != '0) ? PH_HSKIP : PH_SMAGIC;
            end
         end
         PH_HSKIP: begin
            s.size = s.size - 64'd1;
            if (s.size == '0) begin
               s.phase = PH_SMAGIC;
            end
         end
         PH_SMAGIC: begin
            if (b != segment_magic(s.left[1:0])) begin
               s.phase  = PH_DONE;
               s.status = STATUS_NO_SEGMENT;
            end else if (s.left[1:0] == 2'd3) begin
               s.phase = PH_SSIZE;
               s.left  = '0;
            end else begin
               s.left = s.left + 4'd1;
            end
         end
         PH_SSIZE, PH_SSIZE_MORE: begin
            if (state_ff.phase == PH_SSIZE && b == 8'd0) begin
               s.phase  = PH_DONE;
               s.status = STATUS_NO_SEGMENT;
            end else begin
               if (state_ff.phase == PH_SSIZE) begin
                  s.size     = 64'(b & vmask);
                  s.all_ones = (b & vmask) == vmask;
                  s.left     = len - 4'd1;
               end else begin
                  s.size     = {s.size[55:0], b};
                  s.all_ones = s.all_ones && (b == 8'hFF);
                  s.left     = s.left - 4'd1;
               end
               if (s.left != 4'd0) begin
                  s.phase = PH_SSIZE_MORE;
               end else begin
                  s.unb[0]  = s.all_ones;
                  s.lend[0] = s.all_ones ? '0 : sat_add(pos_new, s.size);
                  s.kind[0] = K_SEG;
                  s.depth   = '0;
                  s.phase   = PH_ID;
               end
            end
         end
         PH_ID: begin
            if (b < 8'h10) begin
               s.phase = (s.depth == 3'd0) ? PH_DONE : PH_DRAIN;
               if (s.depth == 3'd0) begin
                  s.status = STATUS_OK;
               end
            end else begin
               s.id    = 32'(b);
               s.left  = len - 4'd1;
               s.phase = (s.left != 4'd0) ? PH_ID_MORE : PH_SIZE;
            end
         end
         PH_ID_MORE: begin
            s.id   = {s.id[23:0], b};
            s.left = s.left - 4'd1;
            if (s.left == 4'd0) begin
               s.phase = PH_SIZE;
            end
         end
         PH_SIZE: begin
            if (b == 8'd0) begin
               s.phase = (s.depth == 3'd0) ? PH_DONE : PH_DRAIN;
               if (s.depth == 3'd0) begin
                  s.status = STATUS_OK;
               end
            end else begin
               s.size     = 64'(b & vmask);
               s.all_ones = (b & vmask) == vmask;
               s.left     = len - 4'd1;
               if (s.left == 4'd0) begin
                  do_open = 1'b1;
               end else begin
                  s.phase = PH_SIZE_MORE;
               end
            end
         end
         PH_SIZE_MORE: begin
            s.size     = {s.size[55:0], b};
            s.all_ones = s.all_ones && (b == 8'hFF);
            s.left     = s.left - 4'd1;
            if (s.left == 4'd0) begin
               do_open = 1'b1;
            end
         end
         PH_CONTENT: begin
            case (s.kind[s.depth])
               K_NUM: begin
                  s.trk = {s.trk[23:0], b};
               end
               K_TYPE: begin
                  s.flags = (b == TYPE_AUDIO) ? (s.flags | 3'b001) : (s.flags & 3'b110);
               end
               K_CODEC: begin
                  if (!s.flags[2]) begin
                     if (b == 8'd0) begin
                        s.flags[2] = 1'b1;
                     end else begin
                        cw      = {s.codec[23:0], b};
                        s.codec = cw;
                        if (cw == OPUS_WORD) begin
                           s.flags[1] = 1'b1;
                        end
                     end
                  end
               end
               K_CHAN: begin
                  s.chtmp = {s.chtmp[7:0], b};
               end
               K_BLOCK: begin
                  if (s.bidx == 3'd0) begin
                     s.bmatch = {24'd0, b & TRACK_MASK} == s.sel;
                     s.bidx   = 3'd1;
                  end else if (s.bidx < 3'd4) begin
                     s.bidx = s.bidx + 3'd1;
                  end else if (s.bmatch) begin
                     last = !s.unb[s.depth] && (pos_new >= s.lend[s.depth]);
                     have_pay         = 1'b1;
                     pay.out_kind     = KIND_PAYLOAD;
                     pay.payload_byte = b;
                     pay.packet_end   = last;
                     s.bidx           = 3'd5;
                     if (last && s.pkt != 16'hFFFF) begin
                        s.pkt = s.pkt + 16'd1;
                     end
                  end
               end
               default: begin
               end
            endcase
         end
         default: begin
         end
      endcase

      // open a child element once its header is complete
      if (do_open) begin
         p = s.depth;
         if (s.kind[p] == K_CLUSTER && s.id == ID_CLUSTER && p != 3'd0) begin
            p = p - 3'd1;
         end
         c = p + 3'd1;
         if (c >= 3'(NLEVELS)) begin
            s.phase = PH_DRAIN;
         end else begin
            case (s.kind[p])
               K_SEG: begin
                  if (s.id == ID_TRACKS && !s.found) begin
                     k = K_TRACKS;
                  end else if (s.id == ID_CLUSTER && s.found) begin
                     k = K_CLUSTER;
                  end
               end
               K_TRACKS: begin
                  if (s.id == ID_TRACKENTRY) begin
                     k = K_ENTRY;
                  end
               end
               K_ENTRY: begin
                  if (s.id == ID_TRACKNUMBER && !s.all_ones && s.size <= 64'd8) begin
                     k = K_NUM;
                  end else if (s.id == ID_TRACKTYPE && !s.all_ones && s.size == 64'd1) begin
                     k = K_TYPE;
                  end else if (s.id == ID_CODECID && !s.all_ones &&
                               s.size < 64'(CODEC_ID_LIMIT)) begin
                     k = K_CODEC;
                  end else if (s.id == ID_AUDIO) begin
                     k = K_AUDIO;
                  end
               end
               K_AUDIO: begin
                  if (s.id == ID_CHANNELS && !s.all_ones && s.size <= 64'd2) begin
                     k = K_CHAN;
                  end
               end
               K_CLUSTER: begin
                  if (s.id == ID_SIMPLEBLOCK) begin
                     k = K_BLOCK;
                  end
               end
               default: begin
               end
            endcase
            if (s.all_ones) begin
               s.lend[c] = s.lend[p];
               s.unb[c]  = s.unb[p];
            end else begin
               e = sat_add(pos_new, s.size);
               if (!s.unb[p] && e > s.lend[p]) begin
                  e = s.lend[p];
               end
               s.lend[c] = e;
               s.unb[c]  = 1'b0;
            end
            case (k)
               K_ENTRY: begin
                  s.trk   = '0;
                  s.flags = '0;
                  s.codec = '0;
                  s.chtmp = 16'd1;
               end
               K_NUM:   s.trk = '0;
               K_CODEC: begin
                  s.codec = '0;
                  s.flags = s.flags & 3'b001;
               end
               K_AUDIO: s.chtmp = 16'd1;
               K_CHAN:  s.chtmp = '0;
               K_BLOCK: begin
                  s.bidx   = '0;
                  s.bmatch = 1'b0;
               end
               default: begin
               end
            endcase
            s.depth   = c;
            s.kind[c] = k;
            s.phase   = (k inside {K_TRACKS, K_ENTRY, K_AUDIO, K_CLUSTER}) ?
                        PH_ID : PH_CONTENT;
         end
      end

      // close every level that ends at this position
      for (int i = 0; i < NLEVELS; i++) begin
         closable[i] = !s.unb[i] && (pos_new >= s.lend[i]);
      end
      run = s.phase inside {[PH_ID:PH_CONTENT]};
      for (int i = 0; i < NLEVELS; i++) begin
         if (run) begin
            if (!closable[s.depth]) begin
               run = 1'b0;
            end else if (s.depth == 3'd0) begin
               s.phase  = PH_DONE;
               s.status = STATUS_OK;
               run      = 1'b0;
            end else begin
               drain = 1'b0;
               if (s.kind[s.depth] == K_ENTRY && !s.found && s.flags[0] && s.flags[1] &&
                   s.trk != '0) begin
                  s.sel   = s.trk;
                  s.found = 1'b1;
                  if (s.chtmp != '0) begin
                     s.chreg = s.chtmp;
                  end
                  drain = 1'b1;
               end
               s.depth = s.depth - 3'd1;
               s.phase = drain ? PH_DRAIN : PH_ID;
            end
         end
      end

      // end of file summary, then back to the reset state
      if (s.phase == PH_MAGIC) begin
         st = STATUS_BAD_EBML;
      end else if (s.phase <= PH_SSIZE_MORE) begin
         st = STATUS_NO_SEGMENT;
      end else if (s.phase == PH_DONE && s.status != STATUS_OK) begin
         st = s.status;
      end else begin
         st = s.found ? STATUS_OK : STATUS_NO_OPUS;
      end
      summ.out_kind       = KIND_SUMMARY;
      summ.packet_aborted = s.phase == PH_CONTENT && s.kind[s.depth] == K_BLOCK &&
                            s.bidx == 3'd5;
      summ.parse_status   = st;
      summ.opus_track     = s.found ? s.sel : '0;
      summ.channel_count  = s.chreg;
      summ.packets_seen   = s.pkt;
      summ.last_of_run    = 1'b1;
      if (req.end_of_file) begin
         s = reset_state();
      end

      state_in    = s;
      push.count  = accept ? ({1'b0, have_pay} + {1'b0, req.end_of_file}) : 2'd0;
      push.first  = have_pay ? pay : summ;
      push.second = summ;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= reset_state();
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

   // nesting never goes past the deepest level
   assert property (@(posedge clock) disable iff (reset) state_ff.depth <= 3'd4)
      else $error("nesting depth out of range");

   // every accepted end of file produces a summary as the last result
   assert property (@(posedge clock) disable iff (reset)
      (accept && req.end_of_file) |-> (push.count != 2'd0) &&
      ((push.count == 2'd2) ? push.second.last_of_run : push.first.last_of_run))
      else $error("end of file without summary");

   // parser restarts for the next file after a summary
   assert property (@(posedge clock) disable iff (reset)
      (accept && req.end_of_file) |=> state_ff.phase == PH_MAGIC &&
      state_ff.pos == '0 && state_ff.pkt == '0)
      else $error("parser not restarted after end of file");

endmodule

>>> rtl/webm_opus_packet_extractor_unit.sv
`timescale 1ns / 1ps
// each accepted request's results are registered in the result queue and reach rsp behind any results already queued
// throughput: one request per cycle while req_stall is low; a byte yields at most two results
// req_stall rises while the result queue has fewer than two free slots
// reset (synchronous, active high) clears the parser and empties the queue
// after each end-of-file summary the parser returns to its reset state
module webm_opus_packet_extractor_unit #(
   parameter int POS_BITS       = wope_pkg::POS_BITS_DEFAULT,
   parameter int CODEC_ID_LIMIT = wope_pkg::CODEC_ID_LIMIT_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  wope_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output wope_pkg::rsp_type rsp_data
);
   import wope_pkg::*;

   push_type push;
   logic     accept;

   // request handshake
   assign accept = req_valid && !req_stall;

   wope_parser #(
      .POS_BITS       (POS_BITS),
      .CODEC_ID_LIMIT (CODEC_ID_LIMIT)
   ) u_parser (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_data),
      .push   (push)
   );

   wope_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .no_room   (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
